/* hdl/dstc_pkg.sv */
// Shared types and codes for the dual stepper tick controller.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package dstc_pkg;

  // Field widths.
  localparam int unsigned DirW   = 2;
  localparam int unsigned DriveW = 2;
  localparam int unsigned PosW   = 32;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned DivW   = SpeedW + 1;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Direction command codes.
  localparam logic [DirW-1:0] DIR_STOP = 2'd0;
  localparam logic [DirW-1:0] DIR_FWD  = 2'd1;
  localparam logic [DirW-1:0] DIR_BACK = 2'd2;

  // Drive action codes.
  localparam logic [DriveW-1:0] DRV_NONE = 2'd0;
  localparam logic [DriveW-1:0] DRV_STOP = 2'd1;
  localparam logic [DriveW-1:0] DRV_FWD  = 2'd2;
  localparam logic [DriveW-1:0] DRV_BACK = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_SPEED_M1 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SPEED_M2 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_M1   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_M2   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FLOOR    = 3'd4;

  // Configuration reset values.
  localparam logic [SpeedW-1:0] SPEED_RST = 16'd0;
  localparam logic [PosW-1:0]   MAX_RST   = 32'hFFFF_FFFF;
  localparam logic [SpeedW-1:0] FLOOR_RST = 16'd1;

  // Per-motor settings handed to a motor unit.
  typedef struct packed {
    logic [SpeedW-1:0] speed;
    logic [SpeedW-1:0] floor;
    logic [PosW-1:0]   max_pos;
  } motor_cfg_t;

endpackage

`default_nettype wire

/* hdl/dstc_if.sv */
// Handshake interfaces for the tick, result and configuration channels.
// Depends on dstc_pkg for field widths.
`default_nettype none

interface dstc_tick_if;
  logic                        valid;
  logic                        ready;
  logic [dstc_pkg::DirW-1:0]   dir_motor1;
  logic [dstc_pkg::DirW-1:0]   dir_motor2;
  logic [dstc_pkg::PosW-1:0]   target_motor1;
  logic [dstc_pkg::PosW-1:0]   target_motor2;

  modport source (output valid, dir_motor1, dir_motor2, target_motor1, target_motor2,
                  input ready);
  modport sink (input valid, dir_motor1, dir_motor2, target_motor1, target_motor2,
                output ready);
endinterface

interface dstc_result_if;
  logic                        valid;
  logic                        ready;
  logic [dstc_pkg::DriveW-1:0] drive_motor1;
  logic [dstc_pkg::DriveW-1:0] drive_motor2;
  logic [dstc_pkg::PosW-1:0]   pos_motor1;
  logic [dstc_pkg::PosW-1:0]   pos_motor2;
  logic                        in_position_mode;

  modport source (output valid, drive_motor1, drive_motor2, pos_motor1, pos_motor2,
                  in_position_mode, input ready);
  modport sink (input valid, drive_motor1, drive_motor2, pos_motor1, pos_motor2,
                in_position_mode, output ready);
endinterface

interface dstc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dstc_pkg::CfgIdxW-1:0]  index;
  logic [dstc_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hdl/dstc_motor.sv */
// One motor unit: step dividers, step count and latched goal of one stepper.
// Depends on dstc_pkg for widths, codes and the settings struct.
`default_nettype none

module dstc_motor (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step_en,
  input  wire dstc_pkg::motor_cfg_t        cfg,
  input  wire logic                        fwd_counts_down,
  input  wire logic [dstc_pkg::DirW-1:0]   dir,
  input  wire logic [dstc_pkg::PosW-1:0]   target,
  input  wire logic                        pos_mode,
  output logic [dstc_pkg::PosW-1:0]        goal_latched,
  output logic [dstc_pkg::DriveW-1:0]      drive,
  output logic [dstc_pkg::PosW-1:0]        count_next
);

  logic [dstc_pkg::DivW-1:0] dir_div;
  logic [dstc_pkg::DivW-1:0] pos_div;
  logic [dstc_pkg::PosW-1:0] count;
  logic [dstc_pkg::PosW-1:0] goal;

  logic [dstc_pkg::DivW-1:0] dir_div_next;
  logic [dstc_pkg::DivW-1:0] pos_div_next;
  logic [dstc_pkg::PosW-1:0] goal_next;

  logic [dstc_pkg::DivW-1:0] limit;
  logic [dstc_pkg::DivW-1:0] div_cur;
  logic [dstc_pkg::DivW-1:0] div_inc;
  logic                      fire;
  logic                      is_move;
  logic                      goes_up;
  logic [dstc_pkg::DriveW-1:0] move_code;

  // A new nonzero target replaces the goal for this tick.
  assign goal_latched = (target != '0) ? target : goal;

  // Step-rate divider of the running mode.
  assign limit   = {1'b0, cfg.speed} + {1'b0, cfg.floor};
  assign div_cur = pos_mode ? pos_div : dir_div;
  assign div_inc = div_cur + 1'b1;
  assign fire    = (div_inc >= limit);

  // Direction decode: which way counts up depends on the motor's sense.
  assign is_move   = (dir == dstc_pkg::DIR_FWD) || (dir == dstc_pkg::DIR_BACK);
  assign goes_up   = (dir == dstc_pkg::DIR_FWD) ^ fwd_counts_down;
  assign move_code = (dir == dstc_pkg::DIR_FWD) ? dstc_pkg::DRV_FWD : dstc_pkg::DRV_BACK;

  // Motion decision and next state.
  always_comb begin
    dir_div_next = dir_div;
    pos_div_next = pos_div;
    goal_next    = goal_latched;
    count_next   = count;
    drive        = dstc_pkg::DRV_NONE;
    if (pos_mode) begin
      pos_div_next = fire ? '0 : div_inc;
      if (fire) begin
        priority if (count < goal_latched) begin
          if (cfg.max_pos > count) begin
            count_next = count + 1'b1;
            drive      = dstc_pkg::DRV_FWD;
          end
        end else if (count > goal_latched) begin
          count_next = count - 1'b1;
          drive      = dstc_pkg::DRV_BACK;
        end else begin
          goal_next = '0;
          drive     = dstc_pkg::DRV_STOP;
        end
      end
    end else begin
      dir_div_next = fire ? '0 : div_inc;
      if (fire) begin
        drive = dstc_pkg::DRV_STOP;
        if (is_move) begin
          if (goes_up) begin
            if (count < cfg.max_pos) begin
              count_next = count + 1'b1;
              drive      = move_code;
            end
          end else if (count != '0) begin
            count_next = count - 1'b1;
            drive      = move_code;
          end
        end
      end
    end
  end

  // Motor state advances once per processed tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      dir_div <= '0;
      pos_div <= '0;
      count   <= '0;
      goal    <= '0;
    end else if (step_en) begin
      dir_div <= dir_div_next;
      pos_div <= pos_div_next;
      count   <= count_next;
      goal    <= goal_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/dual_stepper_tick_controller_core.sv */
// Top level of the dual stepper tick controller: tick input register,
// configuration registers, two motor units and the result register.
// Depends on dstc_pkg, the interfaces in dstc_if.sv and dstc_motor.
//
//   channel   | role   | carries
//   ----------+--------+--------------------------------------------------
//   tick_in   | sink   | dir_motor1/2, target_motor1/2, one tick a transfer
//   result    | source | drive_motor1/2, pos_motor1/2, in_position_mode
//   cfg       | sink   | register index and write data, always ready
//
// A tick is held in the input register; the motor units then decide and the
// result register captures the outcome once it is empty or being read, and a
// new tick can be taken every cycle while the result side does not stall.
// Reset (rst, synchronous) clears both stages, the motor state and restores
// the register defaults. A stalled result holds the tick in the input
// register, and tick_in.ready drops only while both stages are full.
`default_nettype none

module dual_stepper_tick_controller_core (
  input  wire logic     clk,
  input  wire logic     rst,
  dstc_tick_if.sink     tick_in,
  dstc_result_if.source result,
  dstc_cfg_if.sink      cfg
);

  // Configuration registers.
  logic [dstc_pkg::SpeedW-1:0] speed_m1;
  logic [dstc_pkg::SpeedW-1:0] speed_m2;
  logic [dstc_pkg::PosW-1:0]   max_m1;
  logic [dstc_pkg::PosW-1:0]   max_m2;
  logic [dstc_pkg::SpeedW-1:0] speed_floor;

  // Input register.
  logic                        in_vld;
  logic [dstc_pkg::DirW-1:0]   in_dir1;
  logic [dstc_pkg::DirW-1:0]   in_dir2;
  logic [dstc_pkg::PosW-1:0]   in_tgt1;
  logic [dstc_pkg::PosW-1:0]   in_tgt2;

  // Result register.
  logic                        out_vld;
  logic [dstc_pkg::DriveW-1:0] out_drv1;
  logic [dstc_pkg::DriveW-1:0] out_drv2;
  logic [dstc_pkg::PosW-1:0]   out_pos1;
  logic [dstc_pkg::PosW-1:0]   out_pos2;
  logic                        out_pmode;

  logic                        advance;
  logic                        pos_mode;
  dstc_pkg::motor_cfg_t        cfg_m1;
  dstc_pkg::motor_cfg_t        cfg_m2;
  logic [dstc_pkg::PosW-1:0]   goal1;
  logic [dstc_pkg::PosW-1:0]   goal2;
  logic [dstc_pkg::DriveW-1:0] drv1;
  logic [dstc_pkg::DriveW-1:0] drv2;
  logic [dstc_pkg::PosW-1:0]   cnt1_next;
  logic [dstc_pkg::PosW-1:0]   cnt2_next;

  // Configuration writes are taken in any cycle.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_m1    <= dstc_pkg::SPEED_RST;
      speed_m2    <= dstc_pkg::SPEED_RST;
      max_m1      <= dstc_pkg::MAX_RST;
      max_m2      <= dstc_pkg::MAX_RST;
      speed_floor <= dstc_pkg::FLOOR_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        dstc_pkg::REG_SPEED_M1: speed_m1    <= cfg.data[dstc_pkg::SpeedW-1:0];
        dstc_pkg::REG_SPEED_M2: speed_m2    <= cfg.data[dstc_pkg::SpeedW-1:0];
        dstc_pkg::REG_MAX_M1:   max_m1      <= cfg.data[dstc_pkg::PosW-1:0];
        dstc_pkg::REG_MAX_M2:   max_m2      <= cfg.data[dstc_pkg::PosW-1:0];
        dstc_pkg::REG_FLOOR:    speed_floor <= cfg.data[dstc_pkg::SpeedW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_m1 = '{speed: speed_m1, floor: speed_floor, max_pos: max_m1};
  assign cfg_m2 = '{speed: speed_m2, floor: speed_floor, max_pos: max_m2};

  // Pipeline flow control.
  assign advance       = in_vld && (!out_vld || result.ready);
  assign tick_in.ready = !in_vld || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (tick_in.ready) begin
      in_vld <= tick_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_in.ready && tick_in.valid) begin
      in_dir1 <= tick_in.dir_motor1;
      in_dir2 <= tick_in.dir_motor2;
      in_tgt1 <= tick_in.target_motor1;
      in_tgt2 <= tick_in.target_motor2;
    end
  end

  // Either latched goal puts both motors in position mode.
  assign pos_mode = (goal1 != '0) || (goal2 != '0);

  dstc_motor u_motor1 (
    .clk             (clk),
    .rst             (rst),
    .step_en         (advance),
    .cfg             (cfg_m1),
    .fwd_counts_down (1'b0),
    .dir             (in_dir1),
    .target          (in_tgt1),
    .pos_mode        (pos_mode),
    .goal_latched    (goal1),
    .drive           (drv1),
    .count_next      (cnt1_next)
  );

  // Motor 2 counts in the opposite sense.
  dstc_motor u_motor2 (
    .clk             (clk),
    .rst             (rst),
    .step_en         (advance),
    .cfg             (cfg_m2),
    .fwd_counts_down (1'b1),
    .dir             (in_dir2),
    .target          (in_tgt2),
    .pos_mode        (pos_mode),
    .goal_latched    (goal2),
    .drive           (drv2),
    .count_next      (cnt2_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (result.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_drv1  <= drv1;
      out_drv2  <= drv2;
      out_pos1  <= cnt1_next;
      out_pos2  <= cnt2_next;
      out_pmode <= pos_mode;
    end
  end

  assign result.valid            = out_vld;
  assign result.drive_motor1     = out_drv1;
  assign result.drive_motor2     = out_drv2;
  assign result.pos_motor1       = out_pos1;
  assign result.pos_motor2       = out_pos2;
  assign result.in_position_mode = out_pmode;

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the dual stepper tick controller core.
// Depends on dstc_pkg and the handshake interfaces; drives ticks with random gaps, result
// stalls and register writes, and checks every result against a tick-level predictor or a directed value.

module tb;
  import dstc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  // Direction code 3 is not defined; the block treats it as stop.
  localparam logic [DirW-1:0] DIR_UNUSED = 2'd3;

  typedef struct packed {
    logic [DirW-1:0] dir1;
    logic [DirW-1:0] dir2;
    logic [PosW-1:0] tgt1;
    logic [PosW-1:0] tgt2;
  } tick_t;

  typedef struct packed {
    logic [DriveW-1:0] drv1;
    logic [DriveW-1:0] drv2;
    logic [PosW-1:0]   pos1;
    logic [PosW-1:0]   pos2;
    logic              pmode;
  } motion_t;

  typedef struct {
    tick_t   t;
    bit      typed;
    motion_t want;
  } stim_row_t;

  typedef struct {
    logic [SpeedW-1:0] s1;
    logic [SpeedW-1:0] s2;
    logic [PosW-1:0]   m1;
    logic [PosW-1:0]   m2;
    logic [SpeedW-1:0] fl;
    int                items;
  } cfg_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  dstc_tick_if   tick_ch ();
  dstc_result_if res_ch ();
  dstc_cfg_if    cfg_ch ();

  dual_stepper_tick_controller_core dut (
    .clk     (clk),
    .rst     (rst),
    .tick_in (tick_ch),
    .result  (res_ch),
    .cfg     (cfg_ch)
  );

  // Predictor copy of the configuration registers.
  logic [SpeedW-1:0] spd1 = SPEED_RST;
  logic [SpeedW-1:0] spd2 = SPEED_RST;
  logic [PosW-1:0]   lim1 = MAX_RST;
  logic [PosW-1:0]   lim2 = MAX_RST;
  logic [SpeedW-1:0] floor_ticks = FLOOR_RST;

  // Predictor copy of the motor state.
  logic [DivW-1:0] ddiv1 = '0;
  logic [DivW-1:0] ddiv2 = '0;
  logic [DivW-1:0] pdiv1 = '0;
  logic [DivW-1:0] pdiv2 = '0;
  logic [PosW-1:0] cnt1 = '0;
  logic [PosW-1:0] cnt2 = '0;
  logic [PosW-1:0] goal1 = '0;
  logic [PosW-1:0] goal2 = '0;

  motion_t   motion_q[$];
  stim_row_t plan[$];
  int        errors = 0;
  int        cycle_count = 0;
  int        src_quiet = 0;
  int        snk_quiet = 0;
  int        dir_spell = 0;

  // Step-rate divider: fires when the incremented count reaches speed plus floor.
  task automatic divider_tick(inout logic [DivW-1:0] div, input logic [SpeedW-1:0] spd,
                              output bit fire);
    logic [DivW-1:0] span;
    logic [DivW-1:0] nxt;
    span = {1'b0, spd} + {1'b0, floor_ticks};
    nxt  = div + 1'b1;
    fire = (nxt >= span);
    div  = fire ? '0 : nxt;
  endtask

  // Direction mode for one motor; up is the command that raises the count.
  task automatic follow_dir(input logic [DirW-1:0] dir, inout logic [PosW-1:0] cnt,
                            input logic [PosW-1:0] lim, input logic [DirW-1:0] up,
                            output logic [DriveW-1:0] drv);
    logic [DriveW-1:0] step;
    step = (dir == DIR_FWD) ? DRV_FWD : DRV_BACK;
    drv  = DRV_STOP;
    if (dir == DIR_FWD || dir == DIR_BACK) begin
      if (dir == up) begin
        if (cnt < lim) begin
          cnt = cnt + 1;
          drv = step;
        end
      end else if (cnt != 0) begin
        cnt = cnt - 1;
        drv = step;
      end
    end
  endtask

  // Position mode for one motor: one step toward the goal (upward steps stop at the limit), clear it on arrival.
  task automatic seek_goal(inout logic [PosW-1:0] cnt, inout logic [PosW-1:0] goal,
                           input logic [PosW-1:0] lim, output logic [DriveW-1:0] drv);
    if (cnt < goal) begin
      if (lim > cnt) begin
        cnt = cnt + 1;
        drv = DRV_FWD;
      end else begin
        drv = DRV_NONE;
      end
    end else if (cnt > goal) begin
      cnt = cnt - 1;
      drv = DRV_BACK;
    end else begin
      goal = '0;
      drv  = DRV_STOP;
    end
  endtask

  // Advance the predicted state by one accepted tick.
  task automatic predict_tick(input tick_t t, output motion_t r);
    bit fire;
    logic [DriveW-1:0] d1;
    logic [DriveW-1:0] d2;
    d1 = DRV_NONE;
    d2 = DRV_NONE;
    if (t.tgt1 != 0) goal1 = t.tgt1;
    if (t.tgt2 != 0) goal2 = t.tgt2;
    r.pmode = (goal1 != 0) || (goal2 != 0);
    if (r.pmode) begin
      divider_tick(pdiv1, spd1, fire);
      if (fire) seek_goal(cnt1, goal1, lim1, d1);
      divider_tick(pdiv2, spd2, fire);
      if (fire) seek_goal(cnt2, goal2, lim2, d2);
    end else begin
      divider_tick(ddiv1, spd1, fire);
      if (fire) follow_dir(t.dir1, cnt1, lim1, DIR_FWD, d1);
      divider_tick(ddiv2, spd2, fire);
      if (fire) follow_dir(t.dir2, cnt2, lim2, DIR_BACK, d2);
    end
    r.drv1 = d1;
    r.drv2 = d2;
    r.pos1 = cnt1;
    r.pos2 = cnt2;
  endtask

  // Gap or stall length for one transfer, with runs of back-to-back traffic.
  function automatic int draw_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  // A nonzero target a few steps from the current count.
  function automatic logic [PosW-1:0] near_target(logic [PosW-1:0] cnt);
    longint v;
    v = cnt;
    v = v + (int'($urandom_range(0, 12)) - 6);
    if (v < 1 || v > 64'hFFFF_FFFF) v = $urandom_range(1, 6);
    return v[PosW-1:0];
  endfunction

  // Target for position-heavy traffic; a far goal is pulled back in half the time.
  function automatic logic [PosW-1:0] pick_target(logic [PosW-1:0] cnt,
                                                  logic [PosW-1:0] goal);
    int r;
    logic [PosW-1:0] offset;
    r      = $urandom_range(0, 99);
    offset = (goal > cnt) ? goal - cnt : cnt - goal;
    if (goal != 0 && offset > 12 && r < 50) return near_target(cnt);
    if (r < 6) return $urandom;
    if (r < 24) return near_target(cnt);
    return '0;
  endfunction

  // During a direction spell, a latched goal may be moved onto the count to clear it.
  function automatic logic [PosW-1:0] free_goal(logic [PosW-1:0] cnt, logic [PosW-1:0] goal);
    if (goal != 0 && $urandom_range(0, 2) == 0) return (cnt != 0) ? cnt : 32'd1;
    return '0;
  endfunction

  function automatic tick_t draw_tick();
    tick_t t;
    t.dir1 = DirW'($urandom_range(0, 3));
    t.dir2 = DirW'($urandom_range(0, 3));
    if (dir_spell == 0 && $urandom_range(0, 19) == 0) dir_spell = $urandom_range(10, 40);
    if (dir_spell != 0) begin
      dir_spell--;
      t.tgt1 = free_goal(cnt1, goal1);
      t.tgt2 = free_goal(cnt2, goal2);
    end else begin
      t.tgt1 = pick_target(cnt1, goal1);
      t.tgt2 = pick_target(cnt2, goal2);
    end
    return t;
  endfunction

  task automatic add_row(input logic [DirW-1:0] d1, input logic [DirW-1:0] d2,
                         input logic [PosW-1:0] t1, input logic [PosW-1:0] t2,
                         input bit typed = 1'b0,
                         input logic [DriveW-1:0] w1 = '0, input logic [DriveW-1:0] w2 = '0,
                         input logic [PosW-1:0] p1 = '0, input logic [PosW-1:0] p2 = '0,
                         input logic pm = 1'b0);
    stim_row_t row;
    row.t     = '{dir1: d1, dir2: d2, tgt1: t1, tgt2: t2};
    row.typed = typed;
    row.want  = '{drv1: w1, drv2: w2, pos1: p1, pos2: p2, pmode: pm};
    plan.push_back(row);
  endtask

  // Offer one tick after a random gap; the expectation is queued on transfer.
  task automatic send_tick(input tick_t t, input bit typed, input motion_t typed_want);
    int gap;
    motion_t pred;
    gap = draw_gap(src_quiet);
    if (gap != 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid         <= 1'b1;
    tick_ch.dir_motor1    <= t.dir1;
    tick_ch.dir_motor2    <= t.dir2;
    tick_ch.target_motor1 <= t.tgt1;
    tick_ch.target_motor2 <= t.tgt2;
    do @(posedge clk); while (!tick_ch.ready);
    predict_tick(t, pred);
    motion_q.push_back(typed ? typed_want : pred);
  endtask

  // One register write; the caller lowers valid after the last one.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_SPEED_M1: spd1 = val[SpeedW-1:0];
      REG_SPEED_M2: spd2 = val[SpeedW-1:0];
      REG_MAX_M1:   lim1 = val;
      REG_MAX_M2:   lim2 = val;
      REG_FLOOR:    floor_ticks = val[SpeedW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_phase(input cfg_set_t c);
    write_reg(REG_SPEED_M1, {16'd0, c.s1});
    write_reg(REG_SPEED_M2, {16'd0, c.s2});
    write_reg(REG_MAX_M1, c.m1);
    write_reg(REG_MAX_M2, c.m2);
    write_reg(REG_FLOOR, {16'd0, c.fl});
    cfg_ch.valid <= 1'b0;
  endtask

  // Cycle limit guards against a hung handshake or a lost result.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result sink: random stall before each transfer.
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap(snk_quiet);
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    motion_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (motion_q.size() == 0) begin
        $error("result transfer with no expectation pending");
        errors++;
      end else begin
        want = motion_q.pop_front();
        if (res_ch.drive_motor1 !== want.drv1) begin
          $error("drive_motor1 expected %0d got %0d", want.drv1, res_ch.drive_motor1);
          errors++;
        end
        if (res_ch.drive_motor2 !== want.drv2) begin
          $error("drive_motor2 expected %0d got %0d", want.drv2, res_ch.drive_motor2);
          errors++;
        end
        if (res_ch.pos_motor1 !== want.pos1) begin
          $error("pos_motor1 expected %0d got %0d", want.pos1, res_ch.pos_motor1);
          errors++;
        end
        if (res_ch.pos_motor2 !== want.pos2) begin
          $error("pos_motor2 expected %0d got %0d", want.pos2, res_ch.pos_motor2);
          errors++;
        end
        if (res_ch.in_position_mode !== want.pmode) begin
          $error("in_position_mode expected %0d got %0d", want.pmode,
                 res_ch.in_position_mode);
          errors++;
        end
      end
    end
  end

  initial begin
    cfg_set_t phases[$];
    cfg_set_t c;
    tick_t t;

    tick_ch.valid         = 1'b0;
    tick_ch.dir_motor1    = DIR_STOP;
    tick_ch.dir_motor2    = DIR_STOP;
    tick_ch.target_motor1 = '0;
    tick_ch.target_motor2 = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = REG_SPEED_M1;
    cfg_ch.data           = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks under reset settings: one step per tick for both motors.
    add_row(DIR_FWD, DIR_BACK, 0, 0, 1, DRV_FWD, DRV_BACK, 1, 1, 0);
    add_row(DIR_BACK, DIR_FWD, 0, 0, 1, DRV_BACK, DRV_FWD, 0, 0, 0);
    // Both motors at zero and asked to lower the count.
    add_row(DIR_BACK, DIR_FWD, 0, 0, 1, DRV_STOP, DRV_STOP, 0, 0, 0);
    add_row(DIR_STOP, DIR_UNUSED, 0, 0, 1, DRV_STOP, DRV_STOP, 0, 0, 0);
    add_row(DIR_UNUSED, DIR_STOP, 0, 0, 1, DRV_STOP, DRV_STOP, 0, 0, 0);
    // Goal on motor 1 only; motor 2 has no goal and sits at zero.
    add_row(DIR_STOP, DIR_STOP, 2, 0, 1, DRV_FWD, DRV_STOP, 1, 0, 1);
    add_row(DIR_STOP, DIR_STOP, 0, 0, 1, DRV_FWD, DRV_STOP, 2, 0, 1);
    add_row(DIR_STOP, DIR_STOP, 0, 0, 1, DRV_STOP, DRV_STOP, 2, 0, 1);
    add_row(DIR_STOP, DIR_STOP, 0, 0, 1, DRV_STOP, DRV_STOP, 2, 0, 0);
    // Motor 1 reaches its goal first and then falls back toward zero.
    add_row(DIR_STOP, DIR_STOP, 1, 3, 1, DRV_BACK, DRV_FWD, 1, 1, 1);
    add_row(DIR_STOP, DIR_STOP, 0, 0, 1, DRV_STOP, DRV_FWD, 1, 2, 1);
    add_row(DIR_STOP, DIR_STOP, 0, 0, 1, DRV_BACK, DRV_FWD, 0, 3, 1);
    add_row(DIR_STOP, DIR_STOP, 0, 0, 1, DRV_STOP, DRV_STOP, 0, 3, 1);
    add_row(DIR_FWD, DIR_FWD, 0, 0, 1, DRV_FWD, DRV_FWD, 1, 2, 0);
    add_row(DIR_BACK, DIR_BACK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, DRV_FWD, DRV_FWD, 2, 3, 1);
    add_row(DIR_STOP, DIR_STOP, 2, 3, 1, DRV_STOP, DRV_STOP, 2, 3, 1);
    add_row(DIR_FWD, DIR_BACK, 0, 0, 1, DRV_FWD, DRV_BACK, 3, 4, 0);
    add_row(DIR_STOP, DIR_STOP, 32'h8000_0000, 0);
    add_row(DIR_FWD, DIR_BACK, 1, 32'h5555_5555);
    add_row(DIR_BACK, DIR_FWD, 0, 32'h2AAA_AAAA);
    add_row(DIR_STOP, DIR_STOP, 0, 6);
    add_row(DIR_STOP, DIR_STOP, 0, 0);
    add_row(DIR_STOP, DIR_STOP, 0, 0);
    add_row(DIR_FWD, DIR_FWD, 0, 0);

    foreach (plan[i]) send_tick(plan[i].t, plan[i].typed, plan[i].want);

    // Settings for the random part, the extremes among them.
    phases.push_back('{s1: 0, s2: 0, m1: 5, m2: 4, fl: 0, items: 180});
    phases.push_back('{s1: 1, s2: 2, m1: 20, m2: 15, fl: 1, items: 180});
    phases.push_back('{s1: 16'hFFFF, s2: 16'hFFFF, m1: 32'hFFFF_FFFF, m2: 32'hFFFF_FFFF,
                       fl: 16'hFFFF, items: 40});
    phases.push_back('{s1: 0, s2: 3, m1: 0, m2: 32'hFFFF_FFFF, fl: 0, items: 150});
    phases.push_back('{s1: 0, s2: 0, m1: 30, m2: 30, fl: 1, items: 150});
    repeat (3) begin
      c.s1    = SpeedW'($urandom_range(0, 2));
      c.s2    = SpeedW'($urandom_range(0, 2));
      c.m1    = $urandom_range(0, 25);
      c.m2    = $urandom_range(0, 25);
      c.fl    = SpeedW'($urandom_range(0, 2));
      c.items = 120;
      phases.push_back(c);
    end

    // Each phase starts only once the block has drained.
    foreach (phases[p]) begin
      tick_ch.valid <= 1'b0;
      while (motion_q.size() != 0) @(posedge clk);
      program_phase(phases[p]);
      repeat (phases[p].items) begin
        t = draw_tick();
        send_tick(t, 1'b0, '0);
      end
    end

    tick_ch.valid <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
